FILE: src/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// shared types and constants for the fifo queue with delete-by-value
// ----------------------------------------------------------------------------
`default_nettype none

package fqd_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [LEN_W-1:0]       t_len;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_DEL = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;
        logic enq;
        logic deq;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: src/fqd_if.sv
// ----------------------------------------------------------------------------
// fqd_if
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface fqd_in_if;
    logic                              valid;
    logic                              ready;
    logic [fqd_pkg::OP_W-1:0]          operation;
    logic [fqd_pkg::VALUE_WIDTH-1:0]   item_value;

    modport source (output valid, output operation, output item_value, input ready);
    modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface fqd_out_if;
    logic                              valid;
    logic                              ready;
    logic [fqd_pkg::ST_W-1:0]          status;
    logic [fqd_pkg::VALUE_WIDTH-1:0]   value_out;
    logic [fqd_pkg::LEN_W-1:0]         length;

    modport source (output valid, output status, output value_out, output length,
                    input ready);
    modport sink   (input valid, input status, input value_out, input length,
                    output ready);
endinterface

`default_nettype wire

FILE: src/fqd_cell.sv
// ----------------------------------------------------------------------------
// fqd_cell
// one queue position: holds a token, matches it, shifts from its neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_cell (
    input  wire logic                i_clk,
    input  wire fqd_pkg::t_cell_ctl  i_ctl,
    input  wire logic                i_valid,
    input  wire logic                i_tail,
    input  wire fqd_pkg::t_value     i_key,
    input  wire logic                i_prev_hit,
    input  wire fqd_pkg::t_value     i_next_value,
    output      fqd_pkg::t_value     o_value,
    output      logic                o_hit
);
    import fqd_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   w_match;

    assign w_match = i_valid && (r_value == i_key);
    assign o_hit   = i_prev_hit || w_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.accept) begin
            priority if (i_ctl.enq && i_tail) begin
                n_value = i_key;
            end else if (i_ctl.deq || (i_ctl.del && o_hit)) begin
                n_value = i_next_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

FILE: src/fifo_queue_with_delete.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// bounded fifo of tokens with enqueue, dequeue and delete of first match
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  i_in      in   valid/ready   operation, item_value
//  o_out     out  valid/ready   status, value_out, length
//
//  one word accepted per cycle unless a result is stalled; its result is
//  registered and shown the next cycle. all cells match and shift in the
//  same cycle, so the rate is set by the match/prefix chain across the row
//  of cells. reset clears the entry count and result valid; tokens need none.
//  a stalled result blocks input only while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fqd_in_if.sink    i_in,
    fqd_out_if.source o_out
);
    import fqd_pkg::*;

    t_len      r_count;
    t_len      n_count;
    logic      r_out_valid;
    t_status   r_status;
    t_status   n_status;
    t_value    r_value_out;
    t_value    n_value_out;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_value    w_key;
    t_value    w_vals [DEPTH];
    logic      w_hit  [DEPTH+1];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == t_len'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_key      = i_in.item_value;

    assign w_ctl.accept = w_accept;
    assign w_ctl.enq    = (i_in.operation == OP_ENQ);
    assign w_ctl.deq    = (i_in.operation == OP_DEQ);
    assign w_ctl.del    = (i_in.operation == OP_DEL);

    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_vals[g];
        end else begin : g_mid
            assign w_next = w_vals[g+1];
        end
        fqd_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (r_count > t_len'(g)),
            .i_tail       (r_count == t_len'(g)),
            .i_key        (w_key),
            .i_prev_hit   (w_hit[g]),
            .i_next_value (w_next),
            .o_value      (w_vals[g]),
            .o_hit        (w_hit[g+1])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_value_out = '0;
        unique case (i_in.operation)
            OP_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + t_len'(1);
                end
            end
            OP_DEQ: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value_out = w_vals[0];
                    n_count     = r_count - t_len'(1);
                end
            end
            OP_DEL: begin
                if (w_hit[DEPTH]) begin
                    n_count = r_count - t_len'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_value_out <= n_value_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.value_out = r_value_out;
    assign o_out.length    = r_count;

endmodule

`default_nettype wire

FILE: src/fqd_chk.sv
// ----------------------------------------------------------------------------
// fqd_chk
// port-level checks on the result channel of the queue
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_chk (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [fqd_pkg::ST_W-1:0]        i_status,
    input wire logic [fqd_pkg::VALUE_WIDTH-1:0] i_value_out,
    input wire logic [fqd_pkg::LEN_W-1:0]       i_length
);
    import fqd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_value_out) && $stable(i_length))
        else $error("result word changed while stalled");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_length <= LEN_W'(DEPTH))
        else $error("length beyond depth");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_length == LEN_W'(DEPTH)
            && i_value_out == '0)
        else $error("full reported with room left");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY || i_status == ST_NOT_FOUND)
            |-> i_value_out == '0)
        else $error("token returned on failed operation");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_length == '0)
        else $error("empty reported with entries held");

endmodule

bind fifo_queue_with_delete fqd_chk u_fqd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_value_out (o_out.value_out),
    .i_length    (o_out.length)
);

`default_nettype wire

FILE: bench/fifo_queue_with_delete_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_test
// sends enqueue, dequeue and delete words through the queue in bursts
// while the receiver stalls in changing patterns. a mirror of the queue in
// the bench predicts each result word, and every word that comes out is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_test;
    import fqd_pkg::*;

    localparam int RANDOM_WORDS = 1400;

    typedef struct {
        t_status status;
        t_value  value_out;
        t_len    length;
    } t_result_word;

    class queue_mirror;
        t_value       held[$];
        t_result_word pending_results[$];
        int           mismatches = 0;

        function void note_word(t_op op, t_value v);
            t_result_word r;
            int           hit;
            r.status    = ST_OK;
            r.value_out = '0;
            hit         = -1;
            case (op)
                OP_ENQ: begin
                    if (held.size() >= DEPTH) r.status = ST_FULL;
                    else held.push_back(v);
                end
                OP_DEQ: begin
                    if (held.size() == 0) r.status = ST_EMPTY;
                    else r.value_out = held.pop_front();
                end
                OP_DEL: begin
                    foreach (held[i])
                        if (hit < 0 && held[i] == v) hit = i;
                    if (hit < 0) r.status = ST_NOT_FOUND;
                    else held.delete(hit);
                end
                default: ;
            endcase
            r.length = t_len'(held.size());
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [ST_W-1:0] status, t_value value_out, t_len length);
            t_result_word r;
            if (pending_results.size() == 0) begin
                $error("result word with none expected: status %0d value_out %h length %0d",
                       status, value_out, length);
                mismatches++;
                return;
            end
            r = pending_results.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                mismatches++;
            end
            if (value_out !== r.value_out) begin
                $error("value_out: expected %h, actual %h", r.value_out, value_out);
                mismatches++;
            end
            if (length !== r.length) begin
                $error("length: expected %0d, actual %0d", r.length, length);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    queue_mirror mirror = new();

    fqd_in_if  in_ch();
    fqd_out_if out_ch();

    fifo_queue_with_delete dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_word(input t_op op, input t_value v);
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.item_value <= v;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        mirror.note_word(op, v);
    endtask

    function automatic t_value pick_token(bit for_delete);
        int roll;
        roll = $urandom_range(0, 99);
        if (for_delete && mirror.held.size() > 0 && roll < 70)
            return mirror.held[$urandom_range(0, mirror.held.size() - 1)];
        if (roll < 85)
            return t_value'($urandom_range(0, 7));
        return t_value'($urandom());
    endfunction

    // mode 0 leans to filling, mode 1 to draining, mode 2 is balanced
    function automatic t_op pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       return roll < 70 ? OP_ENQ : (roll < 85 ? OP_DEQ : OP_DEL);
            1:       return roll < 20 ? OP_ENQ : (roll < 60 ? OP_DEQ : OP_DEL);
            default: return roll < 40 ? OP_ENQ : (roll < 70 ? OP_DEQ : OP_DEL);
        endcase
    endfunction

    // result side: stall patterns change per segment
    initial begin : receiver
        int seg_len;
        int kind;
        int period;
        int on_cnt;
        int cyc;
        bit r;
        out_ch.ready <= 1'b0;
        forever begin
            seg_len = $urandom_range(20, 200);
            kind    = $urandom_range(0, 3);
            period  = $urandom_range(2, 12);
            on_cnt  = $urandom_range(1, period - 1);
            cyc     = 0;
            repeat (seg_len) begin
                case (kind)
                    0:       r = 1'b1;
                    1:       r = $urandom_range(0, 1);
                    2:       r = (cyc % period) < on_cnt;
                    default: r = (cyc % period) == 0;
                endcase
                cyc++;
                out_ch.ready <= r;
                @(posedge clk);
                if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                    mirror.check_word(out_ch.status, out_ch.value_out, out_ch.length);
            end
        end
    end

    initial begin : stimulus
        t_value fill_vals[DEPTH];
        int sent;
        int burst;
        int gap;
        int mode;
        int phase_left;
        t_op op;

        fill_vals = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'hA5A5_A5A5,
            32'h0000_0005, 32'h5A5A_5A5A, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0000_0001, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
            32'hF0F0_F0F0, 32'h0000_0003, 32'hCAFE_0001, 32'h0000_0009
        };

        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_ENQ;
        in_ch.item_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue corners
        send_word(OP_DEQ, 32'h0000_0000);
        send_word(OP_DEL, 32'h0000_0000);
        // fill to the brim, then one more
        foreach (fill_vals[i]) send_word(OP_ENQ, fill_vals[i]);
        send_word(OP_ENQ, 32'h1111_1111);
        // head, tail, duplicate, missing
        send_word(OP_DEL, fill_vals[0]);
        send_word(OP_DEL, fill_vals[DEPTH-1]);
        send_word(OP_DEL, 32'h0000_0005);
        send_word(OP_DEL, 32'h4444_4444);
        send_word(OP_DEQ, 32'h0000_0000);

        sent       = 0;
        mode       = 0;
        phase_left = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (burst) begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                op = pick_op(mode);
                send_word(op, pick_token(op == OP_DEL));
                sent++;
            end
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;

        while (mirror.pending_results.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
src/fqd_pkg.sv
src/fqd_if.sv
src/fqd_cell.sv
src/fifo_queue_with_delete.sv
src/fqd_chk.sv
bench/fifo_queue_with_delete_test.sv
